@@ src/sioc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse index order checker package
// Shared types and constants for the sparse index order checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sioc_pkg;

    localparam int NUM_DIMS    = 4;
    localparam int DIM_W       = 2;
    localparam int COORD_W     = 64;
    localparam int EXTENT_W    = 63;
    localparam int RANK_W      = 3;
    localparam int ORDER_W     = NUM_DIMS * DIM_W;
    localparam int POS_OUT_W   = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 63;

    localparam logic [RANK_W-1:0]  RANK_RESET  = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd228;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BOUNDS  = 3'd1,
        ST_ORDER   = 3'd2,
        ST_REPEAT  = 3'd3,
        ST_MISSING = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANK        = 3'd0,
        REG_EXTENT_0    = 3'd1,
        REG_EXTENT_1    = 3'd2,
        REG_EXTENT_2    = 3'd3,
        REG_EXTENT_3    = 3'd4,
        REG_ORDER_KNOWN = 3'd5,
        REG_DIM_ORDER   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic oob;
        logic gt;
        logic lt;
    } lane_res_t;

    typedef struct packed {
        logic first;
        logic last;
    } s1_ctl_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic               order_known;
        logic [ORDER_W-1:0] dim_order;
    } cfg_t;

endpackage

`default_nettype wire

@@ src/sioc_if.sv @@
// ----------------------------------------------------------------------------
// Sparse index order checker channels
// Valid/ready channels for index entries and for list results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sioc_in_if;
    import sioc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
    logic                      last_entry;

    modport source (output valid, coord_0, coord_1, coord_2, coord_3, last_entry,
                    input ready);
    modport sink (input valid, coord_0, coord_1, coord_2, coord_3, last_entry,
                  output ready);
    modport monitor (input valid, ready, coord_0, coord_1, coord_2, coord_3,
                     last_entry);
endinterface

interface sioc_out_if;
    import sioc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [POS_OUT_W-1:0] bad_position;

    modport source (output valid, status, bad_position, input ready);
    modport sink (input valid, status, bad_position, output ready);
    modport monitor (input valid, ready, status, bad_position);
endinterface

`default_nettype wire

@@ src/sioc_lane.sv @@
// ----------------------------------------------------------------------------
// Sparse index order checker lane
// Holds one dimension of the previous entry and registers the bounds check
// and the signed comparison of the new coordinate against it.
// ----------------------------------------------------------------------------
`default_nettype none

module sioc_lane (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [sioc_pkg::COORD_W-1:0] coord,
    input  logic [sioc_pkg::EXTENT_W-1:0]       extent,
    output sioc_pkg::lane_res_t                 res
);
    import sioc_pkg::*;

    logic signed [COORD_W-1:0] prev_reg;
    lane_res_t                 res_reg;
    lane_res_t                 res_next;

    always_comb
    begin
        res_next.oob = coord[COORD_W-1] || (coord[EXTENT_W-1:0] >= extent);
        res_next.gt  = coord > prev_reg;
        res_next.lt  = coord < prev_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prev_reg <= coord;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ src/sioc_merge.sv @@
// ----------------------------------------------------------------------------
// Sparse index order checker merge stage
// Combines the lane results in permuted order, latches the first error of the
// list and registers the result at the last entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sioc_merge #(
    parameter int POSITION_BITS = 32
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           fire,
    input  logic                                           take,
    input  sioc_pkg::s1_ctl_t                              ctl,
    input  sioc_pkg::lane_res_t [sioc_pkg::NUM_DIMS-1:0]   lanes,
    input  logic [POSITION_BITS-1:0]                       pos,
    input  sioc_pkg::cfg_t                                 cfg,
    output logic                                           res_valid,
    output sioc_pkg::status_t                              res_status,
    output logic [sioc_pkg::POS_OUT_W-1:0]                 res_pos
);
    import sioc_pkg::*;

    logic                     any_reg;
    logic                     any_next;
    logic                     ff_reg;
    logic                     ff_next;
    status_t                  code_reg;
    status_t                  code_next;
    logic [POSITION_BITS-1:0] epos_reg;
    logic [POSITION_BITS-1:0] epos_next;
    logic                     valid_reg;
    logic                     valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [POS_OUT_W-1:0]     pos_reg;
    logic [POS_OUT_W-1:0]     pos_next;

    logic                     in_bounds;
    logic                     different;
    logic                     increasing;
    status_t                  code_now;
    logic [POSITION_BITS+POS_OUT_W-1:0] epos_ext;

    always_comb
    begin
        logic [DIM_W-1:0] od;
        in_bounds  = 1'b1;
        different  = ctl.first;
        increasing = 1'b1;
        od         = '0;
        for (int k = 0; k < NUM_DIMS; k++)
        begin
            if (RANK_W'(k) < cfg.rank)
            begin
                od = cfg.dim_order[DIM_W*k +: DIM_W];
                if (lanes[k].oob)
                begin
                    in_bounds = 1'b0;
                end
                if (!ctl.first)
                begin
                    if (lanes[od].gt)
                    begin
                        different = 1'b1;
                    end
                    if (!different && lanes[od].lt)
                    begin
                        increasing = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (!in_bounds)
        begin
            code_now = ST_BOUNDS;
        end
        else if (!increasing)
        begin
            code_now = ST_ORDER;
        end
        else if (!different)
        begin
            code_now = ST_REPEAT;
        end
        else
        begin
            code_now = ST_OK;
        end
    end

    always_comb
    begin
        ff_next   = ff_reg || lanes[0].oob || (!ctl.first && !lanes[0].gt);
        any_next  = any_reg;
        code_next = code_reg;
        epos_next = epos_reg;
        if (!any_reg && code_now != ST_OK)
        begin
            any_next  = 1'b1;
            code_next = code_now;
            epos_next = pos;
        end
    end

    assign epos_ext = {{POS_OUT_W{1'b0}}, epos_next};

    always_comb
    begin
        if (cfg.rank == RANK_W'(1) && !ff_next)
        begin
            status_next = ST_OK;
            pos_next    = '0;
        end
        else if (!cfg.order_known)
        begin
            status_next = ST_MISSING;
            pos_next    = '0;
        end
        else if (any_next)
        begin
            status_next = code_next;
            pos_next    = epos_ext[POS_OUT_W-1:0];
        end
        else
        begin
            status_next = ST_OK;
            pos_next    = '0;
        end
    end

    always_comb
    begin
        if (fire && ctl.last)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg   <= 1'b0;
            ff_reg    <= 1'b0;
            code_reg  <= ST_OK;
            epos_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
            begin
                if (ctl.last)
                begin
                    any_reg  <= 1'b0;
                    ff_reg   <= 1'b0;
                    code_reg <= ST_OK;
                    epos_reg <= '0;
                end
                else
                begin
                    any_reg  <= any_next;
                    ff_reg   <= ff_next;
                    code_reg <= code_next;
                    epos_reg <= epos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ctl.last)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
        end
    end

    assign res_valid  = valid_reg;
    assign res_status = status_reg;
    assign res_pos    = pos_reg;

endmodule

`default_nettype wire

@@ src/sparse_index_order_checker_unit.sv @@
// ----------------------------------------------------------------------------
// Sparse index order checker unit
// Checks the coordinates of a sparse index list for bounds and strict
// lexicographic order under a configurable dimension permutation.
// ----------------------------------------------------------------------------
// Throughput: one entry per cycle unless stalled; four compare lanes cover
// all dimensions. Merge registers the result when the last entry fires.
// A waiting result stalls input only once a further last entry reaches merge.
// Reset clears the list state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_index_order_checker_unit #(
    parameter int MAX_RANK      = 4,
    parameter int POSITION_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    sioc_in_if.sink                              entry,
    sioc_out_if.source                           result,
    input  logic                                 cfg_we,
    input  logic [sioc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sioc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sioc_pkg::*;

    logic [RANK_W-1:0]        rank_reg;
    logic [EXTENT_W-1:0]      extent_reg [NUM_DIMS];
    logic                     order_known_reg;
    logic [ORDER_W-1:0]       dim_order_reg;

    logic [POSITION_BITS-1:0] cnt_reg;
    logic [POSITION_BITS-1:0] cnt_next;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    s1_ctl_t                  s1_ctl_reg;
    logic [POSITION_BITS-1:0] s1_pos_reg;

    logic signed [COORD_W-1:0]   coord_in [NUM_DIMS];
    lane_res_t [NUM_DIMS-1:0]    lane_res;
    cfg_t                        cfg;
    logic                        accept;
    logic                        fire;
    logic                        res_valid;
    status_t                     res_status;
    logic [POS_OUT_W-1:0]        res_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg        <= RANK_RESET;
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                extent_reg[i] <= '0;
            end
            order_known_reg <= 1'b1;
            dim_order_reg   <= ORDER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANK:        rank_reg        <= cfg_data[RANK_W-1:0];
                REG_EXTENT_0:    extent_reg[0]   <= cfg_data;
                REG_EXTENT_1:    extent_reg[1]   <= cfg_data;
                REG_EXTENT_2:    extent_reg[2]   <= cfg_data;
                REG_EXTENT_3:    extent_reg[3]   <= cfg_data;
                REG_ORDER_KNOWN: order_known_reg <= cfg_data[0];
                REG_DIM_ORDER:   dim_order_reg   <= cfg_data[ORDER_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.rank        = (rank_reg > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : rank_reg;
        cfg.order_known = order_known_reg;
        cfg.dim_order   = dim_order_reg;
    end

    assign coord_in[0] = entry.coord_0;
    assign coord_in[1] = entry.coord_1;
    assign coord_in[2] = entry.coord_2;
    assign coord_in[3] = entry.coord_3;

    assign fire        = s1_valid_reg && (!s1_ctl_reg.last || !res_valid || result.ready);
    assign entry.ready = !s1_valid_reg || fire;
    assign accept      = entry.valid && entry.ready;

    for (genvar d = 0; d < NUM_DIMS; d++)
    begin : g_lane
        sioc_lane u_lane (
            .clk    (clk),
            .load   (accept),
            .coord  (coord_in[d]),
            .extent (extent_reg[d]),
            .res    (lane_res[d])
        );
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            cnt_next      = entry.last_entry ? '0 : cnt_reg + 1'b1;
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg.first <= (cnt_reg == '0);
            s1_ctl_reg.last  <= entry.last_entry;
            s1_pos_reg       <= cnt_reg;
        end
    end

    sioc_merge #(
        .POSITION_BITS (POSITION_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .take       (result.ready),
        .ctl        (s1_ctl_reg),
        .lanes      (lane_res),
        .pos        (s1_pos_reg),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res_status (res_status),
        .res_pos    (res_pos)
    );

    assign result.valid        = res_valid;
    assign result.status       = res_status;
    assign result.bad_position = res_pos;

endmodule

`default_nettype wire

@@ src/sioc_checker.sv @@
// ----------------------------------------------------------------------------
// Sparse index order checker port assertions
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module sioc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           entry_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic [2:0]                     result_status,
    input logic [sioc_pkg::POS_OUT_W-1:0] result_pos
);
    import sioc_pkg::*;

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_status) && $stable(result_pos))
        else $error("result changed while stalled");

    a_clean_position: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_status == ST_OK || result_status == ST_MISSING)
            |-> result_pos == '0)
        else $error("position reported without an error");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> entry_ready)
        else $error("input stalled with an empty result register");

endmodule

bind sparse_index_order_checker_unit sioc_checker u_sioc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .entry_ready   (entry.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_status (result.status),
    .result_pos    (result.bad_position)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Sparse index order checker testbench
// Streams coordinate lists into the checker under a series of register
// settings, predicts each list verdict from its own model of the bounds and
// lexicographic order checks, and compares every result transfer with it.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sioc_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [63:0] TOP_COORD    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LOW_COORD    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MINUS_ONE    = '1;
    localparam logic [EXTENT_W-1:0] FULL_EXTENT = '1;

    typedef struct packed {
        logic [NUM_DIMS-1:0][COORD_W-1:0] coord;
        logic                             last;
    } entry_item_t;

    typedef struct {
        status_t              status;
        logic [POS_OUT_W-1:0] position;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sioc_in_if  entry_if ();
    sioc_out_if result_if ();

    sparse_index_order_checker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .entry     (entry_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [RANK_W-1:0]    m_rank;
    logic [EXTENT_W-1:0]  m_extent [NUM_DIMS];
    logic                 m_order_known;
    logic [ORDER_W-1:0]   m_dim_order;
    logic [COORD_W-1:0]   m_prev [NUM_DIMS];
    logic [POS_OUT_W-1:0] m_count;
    logic [POS_OUT_W-1:0] m_err_pos;
    status_t              m_err_code;
    bit                   m_err_seen;
    bit                   m_fast_fail;

    entry_item_t pend_q [$];
    verdict_t    verdict_q [$];
    entry_item_t drv_item;
    verdict_t    got_want;

    int fail_cnt          = 0;
    int entries_queued    = 0;
    int entries_in_flight = 0;
    int entries_sent      = 0;
    int lists_done        = 0;
    int settings_cnt      = 0;
    int cycle_cnt         = 0;
    int status_tally [5]  = '{0, 0, 0, 0, 0};
    int burst_left        = 0;
    int gap_left          = 0;
    int stall_mode        = 0;
    int mode_left         = 0;
    int hold_left         = 0;
    bit hold_req          = 1'b0;
    bit hold_done         = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit beyond_extent(input logic [COORD_W-1:0] v,
                                         input logic [EXTENT_W-1:0] lim);
        return v[COORD_W-1] || (v[EXTENT_W-1:0] >= lim);
    endfunction

    function automatic void clear_list_state();
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            m_prev[i] = '0;
        end
        m_count     = '0;
        m_err_code  = ST_OK;
        m_err_pos   = '0;
        m_err_seen  = 1'b0;
        m_fast_fail = 1'b0;
    endfunction

    function automatic void score_entry(input entry_item_t e);
        int               r;
        bit               first;
        bit               in_bounds;
        bit               differs;
        bit               rising;
        logic [DIM_W-1:0] od;
        status_t          code;
        verdict_t         v;
        r         = (m_rank > NUM_DIMS) ? NUM_DIMS : int'(m_rank);
        first     = (m_count == 0);
        in_bounds = 1'b1;
        differs   = first;
        rising    = 1'b1;
        for (int d = 0; d < r; d++)
        begin
            od = m_dim_order[DIM_W*d +: DIM_W];
            if (beyond_extent(e.coord[d], m_extent[d]))
                in_bounds = 1'b0;
            if (!first)
            begin
                if ($signed(e.coord[od]) > $signed(m_prev[od]))
                    differs = 1'b1;
                if (!differs && $signed(e.coord[od]) < $signed(m_prev[od]))
                    rising = 1'b0;
            end
        end
        if (beyond_extent(e.coord[0], m_extent[0]) ||
            (!first && $signed(e.coord[0]) <= $signed(m_prev[0])))
            m_fast_fail = 1'b1;
        if (!m_err_seen)
        begin
            code = ST_OK;
            if (!in_bounds)
                code = ST_BOUNDS;
            else if (!rising)
                code = ST_ORDER;
            else if (!differs)
                code = ST_REPEAT;
            if (code != ST_OK)
            begin
                m_err_seen = 1'b1;
                m_err_code = code;
                m_err_pos  = m_count;
            end
        end
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            m_prev[i] = e.coord[i];
        end
        m_count = m_count + 1'b1;
        if (e.last)
        begin
            if (r == 1 && !m_fast_fail)
                v = '{ST_OK, 32'd0};
            else if (!m_order_known)
                v = '{ST_MISSING, 32'd0};
            else if (m_err_seen)
                v = '{m_err_code, m_err_pos};
            else
                v = '{ST_OK, 32'd0};
            verdict_q.push_back(v);
            status_tally[v.status]++;
            lists_done++;
            clear_list_state();
        end
    endfunction

    function automatic void push_entry(input logic [63:0] c0, c1, c2, c3,
                                       input logic last);
        entry_item_t e;
        e.coord[0] = c0;
        e.coord[1] = c1;
        e.coord[2] = c2;
        e.coord[3] = c3;
        e.last     = last;
        pend_q.push_back(e);
        entries_queued++;
        entries_in_flight++;
    endfunction

    function automatic logic [63:0] wild_coord();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_below(input logic [EXTENT_W-1:0] lim);
        if (lim == 0)
            return 64'd0;
        if (lim <= 32)
            return 64'($urandom_range(0, int'(lim) - 1));
        if ($urandom_range(0, 1) == 1)
            return 64'($urandom_range(0, 15));
        return {1'b0, lim} - 64'd1 - 64'($urandom_range(0, 15));
    endfunction

    function automatic logic [ORDER_W-1:0] random_order();
        int p [NUM_DIMS];
        int j;
        int t;
        p = '{0, 1, 2, 3};
        for (int i = NUM_DIMS - 1; i > 0; i--)
        begin
            j    = $urandom_range(0, i);
            t    = p[i];
            p[i] = p[j];
            p[j] = t;
        end
        return {2'(p[3]), 2'(p[2]), 2'(p[1]), 2'(p[0])};
    endfunction

    function automatic logic [EXTENT_W-1:0] random_extent();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FULL_EXTENT;
            2: return EXTENT_W'({$urandom, $urandom});
            default: return EXTENT_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [EXTENT_W-1:0] small_extent();
        return EXTENT_W'($urandom_range(2, 8));
    endfunction

    // Builds one list that rises under the configured permutation, with a
    // share of entries bent into repeats, drops, negatives or edge values.
    function automatic void queue_list(input int len, input int noise_pct);
        logic [63:0]      cur [NUM_DIMS];
        logic [63:0]      ent [NUM_DIMS];
        logic [63:0]      prev [NUM_DIMS];
        logic [DIM_W-1:0] ord [NUM_DIMS];
        int               gr;
        int               k;
        int               dm;
        gr = (m_rank == 0) ? 1 : ((m_rank > NUM_DIMS) ? NUM_DIMS : int'(m_rank));
        for (int j = 0; j < NUM_DIMS; j++)
        begin
            ord[j]  = m_dim_order[DIM_W*j +: DIM_W];
            cur[j]  = (j < gr) ? pick_below(m_extent[j]) : wild_coord();
            prev[j] = cur[j];
        end
        for (int n = 0; n < len; n++)
        begin
            if (n > 0)
            begin
                k = ($urandom_range(0, 1) == 1) ? gr - 1 : $urandom_range(0, gr - 1);
                cur[ord[k]] = cur[ord[k]] + 64'($urandom_range(1, 2));
                for (int j = k + 1; j < gr; j++)
                begin
                    cur[ord[j]] = pick_below(m_extent[ord[j]]);
                end
                for (int d = gr; d < NUM_DIMS; d++)
                begin
                    cur[d] = wild_coord();
                end
            end
            ent = cur;
            if ($urandom_range(0, 99) < noise_pct)
            begin
                dm = $urandom_range(0, gr - 1);
                case ($urandom_range(0, 4))
                    0: ent = prev;
                    1: ent[dm] = prev[dm] - 64'd1;
                    2: ent[dm] = LOW_COORD | wild_coord();
                    3: ent[dm] = {1'b0, m_extent[dm]};
                    default: ent[dm] = wild_coord();
                endcase
            end
            push_entry(ent[0], ent[1], ent[2], ent[3], n == len - 1);
            prev = ent;
        end
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_RANK:        m_rank = value[RANK_W-1:0];
            REG_EXTENT_0:    m_extent[0] = value;
            REG_EXTENT_1:    m_extent[1] = value;
            REG_EXTENT_2:    m_extent[2] = value;
            REG_EXTENT_3:    m_extent[3] = value;
            REG_ORDER_KNOWN: m_order_known = value[0];
            REG_DIM_ORDER:   m_dim_order = value[ORDER_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic apply_settings(input int rank,
                                  input logic [EXTENT_W-1:0] e0, e1, e2, e3,
                                  input logic known, input logic [ORDER_W-1:0] order);
        write_reg(REG_RANK, CFG_DATA_W'(rank));
        write_reg(REG_EXTENT_0, e0);
        write_reg(REG_EXTENT_1, e1);
        write_reg(REG_EXTENT_2, e2);
        write_reg(REG_EXTENT_3, e3);
        write_reg(REG_ORDER_KNOWN, CFG_DATA_W'(known));
        write_reg(REG_DIM_ORDER, CFG_DATA_W'(order));
        settings_cnt++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (entries_in_flight != 0 || verdict_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_if.valid      <= 1'b0;
            entry_if.coord_0    <= '0;
            entry_if.coord_1    <= '0;
            entry_if.coord_2    <= '0;
            entry_if.coord_3    <= '0;
            entry_if.last_entry <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!entry_if.valid || entry_if.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                entry_if.valid <= 1'b0;
            end
            else if (pend_q.size() != 0)
            begin
                drv_item = pend_q.pop_front();
                entry_if.coord_0    <= drv_item.coord[0];
                entry_if.coord_1    <= drv_item.coord[1];
                entry_if.coord_2    <= drv_item.coord[2];
                entry_if.coord_3    <= drv_item.coord[3];
                entry_if.last_entry <= drv_item.last;
                entry_if.valid      <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                entry_if.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && entry_if.valid === 1'b1 && entry_if.ready === 1'b1)
        begin
            score_entry(entry_item_t'({entry_if.coord_3, entry_if.coord_2,
                                       entry_if.coord_1, entry_if.coord_0,
                                       entry_if.last_entry}));
            entries_in_flight--;
            entries_sent++;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            hold_left  = 0;
            mode_left  = 0;
            stall_mode = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(10, 60);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= 1'($urandom_range(0, 1));
                default: result_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (verdict_q.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result transfer, expected none, %s %0d %0d",
                         $time, "got status and position", result_if.status,
                         result_if.bad_position);
            end
            else
            begin
                got_want = verdict_q.pop_front();
                if (result_if.status !== got_want.status)
                begin
                    fail_cnt++;
                    $display("%0t: status expected %0d got %0d", $time,
                             got_want.status, result_if.status);
                end
                if (result_if.bad_position !== got_want.position)
                begin
                    fail_cnt++;
                    $display("%0t: bad_position expected %0d got %0d", $time,
                             got_want.position, result_if.bad_position);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, verdict_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        int target;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_RANK;
        cfg_data      = '0;
        m_rank        = RANK_RESET;
        m_extent      = '{default: '0};
        m_order_known = 1'b1;
        m_dim_order   = ORDER_RESET;
        clear_list_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: zero extents put every coordinate out of bounds.
        push_entry(64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
        push_entry(64'd5, 64'd0, 64'd0, 64'd0, 1'b0);
        push_entry(64'd3, 64'd0, 64'd0, 64'd0, 1'b1);
        wait_idle();

        apply_settings(4, FULL_EXTENT, FULL_EXTENT, FULL_EXTENT, FULL_EXTENT,
                       1'b1, ORDER_RESET);
        push_entry(TOP_COORD - 64'd1, 64'd0, 64'd0, TOP_COORD - 64'd1, 1'b1);
        push_entry(TOP_COORD, 64'd0, 64'd0, 64'd0, 1'b1);
        push_entry(64'd0, LOW_COORD, 64'd0, 64'd0, 1'b1);
        push_entry(64'd0, 64'd0, 64'd0, 64'd1, 1'b0);
        push_entry(64'd0, 64'd0, 64'd1, 64'd0, 1'b0);
        push_entry(64'd0, 64'd1, 64'd0, 64'd0, 1'b1);
        push_entry(64'd1, 64'd2, 64'd3, 64'd4, 1'b0);
        push_entry(64'd1, 64'd2, 64'd3, 64'd4, 1'b1);
        push_entry(64'd1, 64'd2, 64'd3, 64'd4, 1'b0);
        push_entry(64'd1, 64'd2, 64'd3, 64'd3, 1'b1);
        push_entry(64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
        push_entry(64'd0, 64'd0, 64'd0, MINUS_ONE, 1'b0);
        push_entry(64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
        wait_idle();

        // Rank one without an order: a clean rising list still passes.
        apply_settings(1, 63'd4, 63'd0, 63'd0, 63'd0, 1'b0, ORDER_RESET);
        push_entry(64'd0, MINUS_ONE, LOW_COORD, TOP_COORD, 1'b0);
        push_entry(64'd1, 64'd0, 64'd0, 64'd0, 1'b0);
        push_entry(64'd3, 64'd9, 64'd9, 64'd9, 1'b1);
        push_entry(64'd2, 64'd0, 64'd0, 64'd0, 1'b0);
        push_entry(64'd2, 64'd0, 64'd0, 64'd0, 1'b1);
        wait_idle();

        apply_settings(0, 63'd2, 63'd2, 63'd2, 63'd2, 1'b1, ORDER_RESET);
        push_entry(64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
        push_entry(64'd0, 64'd1, 64'd0, 64'd0, 1'b0);
        push_entry(64'd5, 64'd0, 64'd0, 64'd0, 1'b1);
        wait_idle();

        // Rank above the limit, and every order slot naming dimension zero.
        apply_settings(7, 63'd2, 63'd2, 63'd2, 63'd2, 1'b1, 8'd0);
        push_entry(64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
        push_entry(64'd1, 64'd1, 64'd1, 64'd1, 1'b1);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: apply_settings(4, small_extent(), small_extent(), small_extent(),
                                  small_extent(), 1'b1, ORDER_RESET);
                1: apply_settings(3, random_extent(), random_extent(), random_extent(),
                                  random_extent(), 1'b1, random_order());
                2: apply_settings(2, FULL_EXTENT, FULL_EXTENT, FULL_EXTENT, FULL_EXTENT,
                                  1'b1, random_order());
                3: apply_settings(1, EXTENT_W'($urandom_range(4, 40)), random_extent(),
                                  random_extent(), random_extent(), 1'b0, random_order());
                4: apply_settings($urandom_range(5, 7), small_extent(), small_extent(),
                                  small_extent(), small_extent(), 1'b1, random_order());
                5: apply_settings(4, small_extent(), small_extent(), small_extent(),
                                  small_extent(), 1'b1, ORDER_W'($urandom_range(0, 255)));
                6: apply_settings(0, random_extent(), random_extent(), random_extent(),
                                  random_extent(), 1'($urandom_range(0, 1)), random_order());
                default: apply_settings($urandom_range(1, 4), random_extent(),
                                        random_extent(), random_extent(), random_extent(),
                                        ($urandom_range(0, 3) != 0),
                                        ORDER_W'($urandom_range(0, 255)));
            endcase
            target = entries_queued + 56;
            while (entries_queued < target)
            begin
                queue_list($urandom_range(1, 12), 10 + 2 * p);
            end
            wait_idle();
        end

        // Short lists while the result side holds off, so results back up
        // and the entry channel stalls.
        apply_settings(2, 63'd4, 63'd4, 63'd4, 63'd4, 1'b1, ORDER_RESET);
        hold_req = 1'b1;
        for (int n = 0; n < 60; n++)
        begin
            queue_list($urandom_range(1, 2), 20);
        end
        wait_idle();
        repeat (6) @(posedge clk);

        $display("Run covered %0d entries in %0d lists over %0d register settings.",
                 entries_sent, lists_done, settings_cnt);
        $display("Verdicts: %0d ok, %0d bounds, %0d order, %0d repeat, %0d missing order.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        if (fail_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
